// ===== sv/vnsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and register codes for the Voronoi nearest-seed block.
// No dependencies; every other file imports this package.
package vnsc_pkg;

    localparam int NUM_PAIRS  = 4;
    localparam int NUM_LANES  = 8;
    localparam int COORD_W    = 8;
    localparam int COLOR_W    = 15;
    localparam int SEED_W     = 2 * COORD_W + COLOR_W;
    localparam int PAIR_W     = 2 * SEED_W;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int DIST_W     = SQ_W + 1;
    localparam int IDX_W      = 3;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int PIPE_DEPTH = 6;

    localparam logic [CFG_IDX_W-1:0] REG_SEED_PAIR_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_PAIR_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_PAIR_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_PAIR_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_COUNT  = 3'd4;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_seed;

    typedef struct packed {
        logic              active;
        logic [DIST_W-1:0] sq_dist;
        logic [IDX_W-1:0]  idx;
    } t_cand;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_dist_en;

    typedef struct packed {
        logic s4;
        logic s5;
    } t_tree_en;

    // Candidate a always has the lower index, so it wins ties.
    function automatic t_cand pick_nearest(input t_cand a, input t_cand b);
        t_cand r;
        if (a.active && (!b.active || (a.sq_dist <= b.sq_dist))) begin
            r = a;
        end else begin
            r = b;
        end
        return r;
    endfunction

endpackage

// ===== sv/vnsc_dist.sv =====
`timescale 1ns / 1ps
// One distance lane: absolute differences, squares, and their sum in three stages.
// Depends on vnsc_pkg.
module vnsc_dist import vnsc_pkg::*; (
    input  logic               i_clk,
    input  t_dist_en           i_en,
    input  logic [COORD_W-1:0] i_pixel_x,
    input  logic [COORD_W-1:0] i_pixel_y,
    input  logic [COORD_W-1:0] i_seed_x,
    input  logic [COORD_W-1:0] i_seed_y,
    output logic [DIST_W-1:0]  o_dist
);

    logic [COORD_W-1:0] r_dx, r_dy, n_dx, n_dy;
    logic [SQ_W-1:0]    r_sx, r_sy;
    logic [DIST_W-1:0]  r_dist;

    always_comb begin
        n_dx = (i_seed_x > i_pixel_x) ? (i_seed_x - i_pixel_x) : (i_pixel_x - i_seed_x);
        n_dy = (i_seed_y > i_pixel_y) ? (i_seed_y - i_pixel_y) : (i_pixel_y - i_seed_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
        if (i_en.s2) begin
            r_sx <= SQ_W'(r_dx) * SQ_W'(r_dx);
            r_sy <= SQ_W'(r_dy) * SQ_W'(r_dy);
        end
        if (i_en.s3) begin
            r_dist <= DIST_W'(r_sx) + DIST_W'(r_sy);
        end
    end

    assign o_dist = r_dist;

endmodule

// ===== sv/vnsc_argmin.sv =====
`timescale 1ns / 1ps
// Registered reduction tree: eight candidates to four, then four to two.
// Depends on vnsc_pkg.
module vnsc_argmin import vnsc_pkg::*; (
    input  logic                        i_clk,
    input  t_tree_en                    i_en,
    input  t_cand [NUM_LANES-1:0]       i_cand,
    output t_cand [NUM_LANES/4-1:0]     o_cand
);

    t_cand [NUM_LANES/2-1:0] r_l1;
    t_cand [NUM_LANES/4-1:0] r_l2;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NUM_LANES / 2; j++) begin
            if (i_en.s4) begin
                r_l1[j] <= pick_nearest(i_cand[2*j], i_cand[2*j+1]);
            end
        end
        for (int j = 0; j < NUM_LANES / 4; j++) begin
            if (i_en.s5) begin
                r_l2[j] <= pick_nearest(r_l1[2*j], r_l1[2*j+1]);
            end
        end
    end

    assign o_cand = r_l2;

endmodule

// ===== sv/voronoi_nearest_seed_color.sv =====
`timescale 1ns / 1ps
// Top level of the Voronoi nearest-seed color block: seed registers, handshake, output stage.
// Depends on vnsc_pkg, vnsc_dist and vnsc_argmin.

// This block takes one pixel coordinate per beat and returns the color and
// index of the nearest configured seed by squared Euclidean distance, the
// lowest index winning ties. It sustains one pixel per clock while the output
// is not stalled; each result passes through the pipeline in order: three
// stages of per-seed distance (difference, square, sum), two stages of the
// minimum tree, and the output stage, which makes the final comparison and
// looks up the winning seed's color. Every stage holds its own valid bit and
// fills any bubble ahead of it, so a stall on the output stops only as much of
// the pipeline as is full, and the input stall rises only when all six stages
// hold items. Seeds are written through the configuration port, which is
// always ready; writes should be made while no pixel is in flight. A seed
// count of zero is stored as one, and a count above MAX_SEEDS as MAX_SEEDS.
// Writes to indexes past the seed count register are dropped.
module voronoi_nearest_seed_color import vnsc_pkg::*; #(
    parameter int MAX_SEEDS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [COORD_W-1:0]   i_pixel_x,
    input  logic [COORD_W-1:0]   i_pixel_y,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [COLOR_W-1:0]   o_pixel_color,
    output logic [IDX_W-1:0]     o_nearest_index,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PAIR_W-1:0]    i_cfg_data
);

    // Configuration registers. The count is kept clamped to 1..MAX_SEEDS.
    logic [PAIR_W-1:0] r_seed_pair [NUM_PAIRS];
    logic [CNT_W-1:0]  r_seed_count;
    logic [CNT_W-1:0]  n_seed_count;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_seed_count = i_cfg_data[CNT_W-1:0];
        if (n_seed_count == '0) begin
            n_seed_count = CNT_W'(1);
        end
        if (n_seed_count > CNT_W'(MAX_SEEDS)) begin
            n_seed_count = CNT_W'(MAX_SEEDS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PAIRS; p++) begin
                r_seed_pair[p] <= '0;
            end
            r_seed_count <= CNT_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SEED_PAIR_A: r_seed_pair[0] <= i_cfg_data;
                REG_SEED_PAIR_B: r_seed_pair[1] <= i_cfg_data;
                REG_SEED_PAIR_C: r_seed_pair[2] <= i_cfg_data;
                REG_SEED_PAIR_D: r_seed_pair[3] <= i_cfg_data;
                REG_SEED_COUNT:  r_seed_count   <= n_seed_count;
                default: begin
                end
            endcase
        end
    end

    // Each pair register holds the even seed in its low half.
    t_seed w_seed [NUM_LANES];

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_seed
        assign w_seed[i] = t_seed'(r_seed_pair[i / 2][(i % 2) * SEED_W +: SEED_W]);
    end

    // Stage control. A stage loads when it is empty or when the stage after
    // it moves on, so bubbles close up even while the output is stalled.
    logic [PIPE_DEPTH:1]   r_vld;
    logic [PIPE_DEPTH+1:1] w_ready;
    logic [PIPE_DEPTH:1]   w_vld_in;

    assign w_ready[PIPE_DEPTH+1] = !i_stall;
    assign w_vld_in[1]           = i_valid;

    for (genvar k = 1; k <= PIPE_DEPTH; k++) begin : g_stage
        assign w_ready[k] = !r_vld[k] || w_ready[k+1];
        if (k > 1) begin : g_chain
            assign w_vld_in[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= PIPE_DEPTH; k++) begin
                if (w_ready[k]) begin
                    r_vld[k] <= w_vld_in[k];
                end
            end
        end
    end

    assign o_stall = !w_ready[1];
    assign o_valid = r_vld[PIPE_DEPTH];

    t_dist_en w_dist_en;
    t_tree_en w_tree_en;

    assign w_dist_en = '{s1: w_ready[1], s2: w_ready[2], s3: w_ready[3]};
    assign w_tree_en = '{s4: w_ready[4], s5: w_ready[5]};

    // Distance lanes. Lanes at or above MAX_SEEDS are never built and never
    // take part in the minimum.
    logic [DIST_W-1:0]       w_dist [NUM_LANES];
    t_cand [NUM_LANES-1:0]   w_cand;

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        if (i < MAX_SEEDS) begin : g_used
            vnsc_dist u_dist (
                .i_clk     (i_clk),
                .i_en      (w_dist_en),
                .i_pixel_x (i_pixel_x),
                .i_pixel_y (i_pixel_y),
                .i_seed_x  (w_seed[i].x),
                .i_seed_y  (w_seed[i].y),
                .o_dist    (w_dist[i])
            );
            // The user must change the count only while the pipeline is empty (the block
            // does not enforce it), so it is read here rather than carried with the item.
            assign w_cand[i].active = (r_seed_count > CNT_W'(i));
        end else begin : g_unused
            assign w_dist[i]        = '0;
            assign w_cand[i].active = 1'b0;
        end
        assign w_cand[i].sq_dist = w_dist[i];
        assign w_cand[i].idx     = IDX_W'(i);
    end

    t_cand [NUM_LANES/4-1:0] w_half;

    vnsc_argmin u_argmin (
        .i_clk  (i_clk),
        .i_en   (w_tree_en),
        .i_cand (w_cand),
        .o_cand (w_half)
    );

    // Output stage: the last comparison and the color lookup for the winner.
    t_cand              w_best;
    logic [COLOR_W-1:0] r_color;
    logic [IDX_W-1:0]   r_index;

    assign w_best = pick_nearest(w_half[0], w_half[1]);

    always_ff @(posedge i_clk) begin
        if (w_ready[PIPE_DEPTH]) begin
            r_color <= w_seed[w_best.idx].color;
            r_index <= w_best.idx;
        end
    end

    assign o_pixel_color   = r_color;
    assign o_nearest_index = r_index;

endmodule

// ===== sv/vnsc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the Voronoi nearest-seed block, with its bind to the top level.
// Depends on vnsc_pkg and voronoi_nearest_seed_color.
module vnsc_checker import vnsc_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [COLOR_W-1:0]   o_pixel_color,
    input logic [IDX_W-1:0]     o_nearest_index,
    input logic                 o_cfg_ready
);

    // Beats accepted but not yet delivered.
    logic [CNT_W-1:0] r_inflight;
    logic             w_in_beat;
    logic             w_out_beat;

    assign w_in_beat  = i_valid && !o_stall;
    assign w_out_beat = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + CNT_W'(w_in_beat) - CNT_W'(w_out_beat);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel_color)
                                  && $stable(o_nearest_index)))
        else $error("result changed while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_inflight != '0))
        else $error("result without an accepted pixel");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CNT_W'(PIPE_DEPTH))
        else $error("more pixels in flight than pipeline stages");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_inflight != CNT_W'(PIPE_DEPTH)) || !o_valid) |-> !o_stall)
        else $error("input stalled with room in the pipeline");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind voronoi_nearest_seed_color vnsc_checker u_vnsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_pixel_color   (o_pixel_color),
    .o_nearest_index (o_nearest_index),
    .o_cfg_ready     (o_cfg_ready)
);
